>>> src/ipd_pkg.sv
`default_nettype none
package ipd_pkg;

	localparam int unsigned NUM_SOURCES = 5;
	localparam int unsigned SRC_IDX_W = 3;
	localparam logic [NUM_SOURCES-1:0] SOURCE_MASK = 5'h1F;
	localparam logic [6:0] VECTOR_BASE = 7'h40;
	localparam logic [2:0] DISPATCH_CYCLES = 3'd5;
	localparam logic [15:0] PUSH_BYTES = 16'd2;

	typedef enum logic [1:0] {
		REQ_BOUNDARY  = 2'd0,
		REQ_WR_FLAG   = 2'd1,
		REQ_WR_ENABLE = 2'd2
	} req_kind_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [7:0]  write_value;
		logic [4:0]  new_requests;
		logic [15:0] current_pc;
		logic [15:0] current_sp;
		logic        did_enable;
		logic        did_disable;
		logic        did_halt;
	} item_t;

	typedef struct packed {
		logic        dispatched;
		logic [6:0]  vector_address;
		logic [15:0] push_address;
		logic [15:0] push_value;
		logic [2:0]  extra_cycles;
		logic        is_halted;
		logic        master_enable;
		logic [7:0]  flag_readback;
		logic [7:0]  enable_readback;
	} result_t;

	// Vectors sit eight bytes apart, starting at 0x40.
	function automatic logic [6:0] vector_of(input logic [SRC_IDX_W-1:0] idx);
		return VECTOR_BASE + {1'b0, idx, 3'b000};
	endfunction

endpackage
`default_nettype wire

>>> src/ipd_stream_if.sv
`default_nettype none
interface ipd_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> src/ipd_eval.sv
`default_nettype none
module ipd_eval (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           fire,
	input  wire ipd_pkg::item_t item,
	output ipd_pkg::result_t    res
);
	import ipd_pkg::*;

	logic [7:0] flag_q;
	logic [7:0] enable_q;
	logic       ime_q;
	logic       ime_delayed_q;
	logic       halt_q;

	logic [7:0] flag_d;
	logic [7:0] enable_d;
	logic       ime_d;
	logic       ime_delayed_d;
	logic       halt_d;

	logic [7:0]             flag_merged;
	logic                   ime_a;
	logic                   delayed_a;
	logic                   ime_b;
	logic                   halt_a;
	logic [NUM_SOURCES-1:0] pending;
	logic [SRC_IDX_W-1:0]   idx;
	logic                   take;

	always_comb begin
		flag_merged = flag_q | {3'b000, item.new_requests};
		ime_a       = item.did_disable ? 1'b0 : ime_q;
		delayed_a   = (item.did_disable ? 1'b0 : ime_delayed_q) | item.did_enable;
		halt_a      = halt_q | item.did_halt;
		// promote a pending enable
		ime_b       = ime_a | delayed_a;
		pending     = flag_merged[NUM_SOURCES-1:0] & enable_q[NUM_SOURCES-1:0] & SOURCE_MASK;
		take        = (pending != '0) && ime_b;

		// lowest-numbered request wins
		idx = SRC_IDX_W'(NUM_SOURCES - 1);
		for (int i = NUM_SOURCES - 2; i >= 0; i--) begin
			if (pending[i]) begin
				idx = SRC_IDX_W'(i);
			end
		end
	end

	always_comb begin
		flag_d        = flag_q;
		enable_d      = enable_q;
		ime_d         = ime_q;
		ime_delayed_d = ime_delayed_q;
		halt_d        = halt_q;

		res                 = '0;

		unique case (req_kind_t'(item.req_type))
			REQ_WR_FLAG: begin
				flag_d = item.write_value;
			end
			REQ_WR_ENABLE: begin
				enable_d = item.write_value;
			end
			REQ_BOUNDARY: begin
				flag_d        = flag_merged;
				ime_d         = ime_b;
				ime_delayed_d = 1'b0;
				halt_d        = (pending != '0) ? 1'b0 : halt_a;
				if (take) begin
					flag_d[idx]        = 1'b0;
					ime_d              = 1'b0;
					res.dispatched     = 1'b1;
					res.vector_address = vector_of(idx);
					res.push_address   = item.current_sp - PUSH_BYTES;
					res.push_value     = item.current_pc;
					res.extra_cycles   = DISPATCH_CYCLES;
				end
			end
			default: begin
			end
		endcase

		res.is_halted       = halt_d;
		res.master_enable   = ime_d;
		res.flag_readback   = flag_d;
		res.enable_readback = enable_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q        <= '0;
			enable_q      <= '0;
			ime_q         <= 1'b0;
			ime_delayed_q <= 1'b0;
			halt_q        <= 1'b0;
		end else if (fire) begin
			flag_q        <= flag_d;
			enable_q      <= enable_d;
			ime_q         <= ime_d;
			ime_delayed_q <= ime_delayed_d;
			halt_q        <= halt_d;
		end
	end

endmodule
`default_nettype wire

>>> src/interrupt_priority_dispatch_top.sv
`default_nettype none
// Interrupt controller: each item (register write or instruction boundary) yields
// exactly one result. An item is captured in an input register, evaluated against
// the flag/enable/master-enable/halt state combinationally and lands in a result
// register. One item per cycle is sustained while results are accepted. The result
// register decouples the two sides, so a stalled result only blocks intake once
// both registers are full.
module interrupt_priority_dispatch_top (
	input wire logic     clk,
	input wire logic     arst_n,
	ipd_stream_if.sink   item,
	ipd_stream_if.source result
);
	import ipd_pkg::*;

	logic    valid_s1;
	item_t   item_s1;
	logic    res_valid_q;
	result_t res_q;
	result_t res_next;
	logic    advance;
	logic    fire;

	assign advance    = !res_valid_q || result.ready;
	assign fire       = valid_s1 && advance;
	assign item.ready = !valid_s1 || advance;

	ipd_eval u_eval (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.res    (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (item.ready) begin
				valid_s1 <= item.valid;
			end
			if (advance) begin
				res_valid_q <= valid_s1;
			end
		end
	end

	// payload registers: hold while stalled
	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1 <= item.data;
		end
		if (fire) begin
			res_q <= res_next;
		end
	end

	assign result.valid = res_valid_q;
	assign result.data  = res_q;

endmodule
`default_nettype wire

>>> src/ipd_checker.sv
`default_nettype none
module ipd_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             res_valid,
	input wire logic             res_ready,
	input wire ipd_pkg::result_t res_data
);
	import ipd_pkg::*;

	// a taken interrupt carries the dispatch cycle cost, jumps to a vector and drops the master enable
	a_taken_shape: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.dispatched |->
			res_data.extra_cycles == DISPATCH_CYCLES && !res_data.master_enable)
		else $error("dispatch result malformed");

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_data.dispatched |->
			res_data.vector_address == 7'd0 && res_data.push_address == 16'd0 &&
			res_data.push_value == 16'd0 && res_data.extra_cycles == 3'd0)
		else $error("non-dispatch result carries dispatch fields");

	// the taken source has its flag cleared
	a_flag_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.dispatched |->
			(res_data.vector_address == 7'h40 && !res_data.flag_readback[0]) ||
			(res_data.vector_address == 7'h48 && !res_data.flag_readback[1]) ||
			(res_data.vector_address == 7'h50 && !res_data.flag_readback[2]) ||
			(res_data.vector_address == 7'h58 && !res_data.flag_readback[3]) ||
			(res_data.vector_address == 7'h60 && !res_data.flag_readback[4]))
		else $error("taken flag not cleared or bad vector");

	// a dispatch always wakes the core
	a_awake: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.dispatched |-> !res_data.is_halted)
		else $error("halted after dispatch");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("result changed while stalled");

endmodule

bind interrupt_priority_dispatch_top ipd_checker u_ipd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_data  (result.data)
);
`default_nettype wire

>>> verif/tb_interrupt_priority_dispatch_top.sv
`default_nettype none
module tb_interrupt_priority_dispatch_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ipd_pkg::*;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 1300;
	localparam int HOLD_OFF_CYCLES = 200;
	localparam int MAX_REPORTS = 10;
	localparam int ITEM_BITS = $bits(item_t);

	typedef enum logic [1:0] {
		DRAIN_FREE,
		DRAIN_COIN,
		DRAIN_SPARSE,
		DRAIN_ALTERNATE
	} drain_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic  in_valid = 1'b0;
	item_t in_data = '0;
	logic  out_ready = 1'b0;

	ipd_stream_if #(.T(item_t))   item_if ();
	ipd_stream_if #(.T(result_t)) result_if ();

	assign item_if.valid = in_valid;
	assign item_if.data = in_data;
	assign result_if.ready = out_ready;

	interrupt_priority_dispatch_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_if),
		.result (result_if)
	);

	// Controller state as the predictor sees it
	logic [7:0] irq_flags = '0;
	logic [7:0] irq_enables = '0;
	logic       ime = 1'b0;
	logic       ime_pending = 1'b0;
	logic       halted = 1'b0;

	item_t   pending_items[$];
	result_t expected_results[$];

	int items_accepted = 0;
	int results_checked = 0;
	int mismatch_count = 0;
	int wake_count = 0;
	int taken_per_source[NUM_SOURCES];

	bit item_moved = 1'b0;
	int burst_left = 1;
	int gap_left = 0;
	bit holding_off = 1'b0;
	drain_mode_t drain_mode = DRAIN_FREE;
	int drain_left = 0;
	int drain_tick = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic result_t resolve_item(input item_t it);
		result_t r;
		logic [4:0] live;
		int src;
		r = '0;
		case (it.req_type)
			REQ_WR_FLAG: irq_flags = it.write_value;
			REQ_WR_ENABLE: irq_enables = it.write_value;
			REQ_BOUNDARY: begin
				irq_flags = irq_flags | {3'b000, it.new_requests};
				if (it.did_disable) begin
					ime = 1'b0;
					ime_pending = 1'b0;
				end
				if (it.did_enable)
					ime_pending = 1'b1;
				if (it.did_halt)
					halted = 1'b1;
				if (ime_pending) begin
					ime = 1'b1;
					ime_pending = 1'b0;
				end
				live = irq_flags[4:0] & irq_enables[4:0] & SOURCE_MASK;
				if (live != '0) begin
					if (halted)
						wake_count++;
					halted = 1'b0;
					if (ime) begin
						src = 0;
						while (src < NUM_SOURCES - 1 && !live[src])
							src++;
						irq_flags[src] = 1'b0;
						ime = 1'b0;
						taken_per_source[src]++;
						r.dispatched = 1'b1;
						r.vector_address = VECTOR_BASE + 7'(src * 8);
						r.push_address = it.current_sp - 16'd2;
						r.push_value = it.current_pc;
						r.extra_cycles = DISPATCH_CYCLES;
					end
				end
			end
			default: ;
		endcase
		r.is_halted = halted;
		r.master_enable = ime;
		r.flag_readback = irq_flags;
		r.enable_readback = irq_enables;
		return r;
	endfunction

	function automatic string describe(input result_t r);
		return $sformatf("take=%0d vec=%h push=%h/%h cyc=%0d halt=%0d ime=%0d if=%h ie=%h",
			r.dispatched, r.vector_address, r.push_address, r.push_value,
			r.extra_cycles, r.is_halted, r.master_enable, r.flag_readback,
			r.enable_readback);
	endfunction

	task automatic queue_boundary(input logic [4:0] reqs, input logic [15:0] pc,
			input logic [15:0] sp, input bit en, input bit dis, input bit hlt);
		item_t it;
		it.req_type = REQ_BOUNDARY;
		it.write_value = 8'($urandom);
		it.new_requests = reqs;
		it.current_pc = pc;
		it.current_sp = sp;
		it.did_enable = en;
		it.did_disable = dis;
		it.did_halt = hlt;
		pending_items.push_back(it);
	endtask

	task automatic queue_other(input logic [1:0] kind, input logic [7:0] val);
		item_t it;
		it = item_t'(ITEM_BITS'({$urandom, $urandom}));
		it.req_type = kind;
		it.write_value = val;
		pending_items.push_back(it);
	endtask

	// Sender: bursts of transfers with random gaps between them
	always @(negedge clk) begin : feed
		bit offer;
		if (arst_n && (!in_valid || item_moved)) begin
			offer = 1'b0;
			if (gap_left != 0) begin
				gap_left--;
			end else if (pending_items.size() != 0) begin
				in_data <= pending_items.pop_front();
				offer = 1'b1;
				burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
			in_valid <= offer;
		end
	end

	// Receiver: stall pattern switches at random among free, coin-flip, sparse and alternate modes
	always @(negedge clk) begin : drain
		bit take;
		if (drain_left == 0) begin
			drain_mode = drain_mode_t'($urandom_range(0, 3));
			drain_left = $urandom_range(20, 120);
		end
		drain_left--;
		drain_tick++;
		case (drain_mode)
			DRAIN_FREE: take = 1'b1;
			DRAIN_COIN: take = $urandom_range(0, 1);
			DRAIN_SPARSE: take = ($urandom_range(0, 3) == 0);
			default: take = drain_tick[0];
		endcase
		if (holding_off)
			take = 1'b0;
		out_ready <= take;
	end

	always @(posedge clk) begin : observe
		result_t want;
		result_t got;
		string diffs;
		item_moved = 1'b0;
		if (arst_n) begin
			if (item_if.valid && item_if.ready) begin
				expected_results.push_back(resolve_item(item_if.data));
				items_accepted++;
				item_moved = 1'b1;
			end
			if (result_if.valid && result_if.ready) begin
				got = result_if.data;
				if (expected_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("%t unexpected result: %s", $realtime, describe(got));
				end else begin
					want = expected_results.pop_front();
					diffs = "";
					if (got.dispatched !== want.dispatched) diffs = {diffs, " dispatched"};
					if (got.vector_address !== want.vector_address) diffs = {diffs, " vector"};
					if (got.push_address !== want.push_address) diffs = {diffs, " push_address"};
					if (got.push_value !== want.push_value) diffs = {diffs, " push_value"};
					if (got.extra_cycles !== want.extra_cycles) diffs = {diffs, " cycles"};
					if (got.is_halted !== want.is_halted) diffs = {diffs, " halted"};
					if (got.master_enable !== want.master_enable) diffs = {diffs, " ime"};
					if (got.flag_readback !== want.flag_readback) diffs = {diffs, " flags"};
					if (got.enable_readback !== want.enable_readback) diffs = {diffs, " enables"};
					if (diffs != "") begin
						mismatch_count++;
						if (mismatch_count <= MAX_REPORTS) begin
							$display("%t result %0d differs in%s", $realtime, results_checked, diffs);
							$display("  expected %s", describe(want));
							$display("  actual   %s", describe(got));
						end
					end
				end
				results_checked++;
			end
		end
	end

	// Long receiver hold-offs so both pipeline registers fill and intake stalls
	initial begin
		while (items_accepted < 300)
			@(posedge clk);
		holding_off = 1'b1;
		repeat (HOLD_OFF_CYCLES) @(posedge clk);
		holding_off = 1'b0;
		while (items_accepted < 900)
			@(posedge clk);
		holding_off = 1'b1;
		repeat (HOLD_OFF_CYCLES) @(posedge clk);
		holding_off = 1'b0;
	end

	initial begin
		#2ms;
		$display("tb_interrupt_priority_dispatch_top: errors");
		$finish;
	end

	initial begin
		int pick;
		logic [4:0] reqs;
		logic [15:0] sp;
		foreach (taken_per_source[i])
			taken_per_source[i] = 0;

		// Directed opening
		queue_boundary(5'h00, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0);
		queue_other(REQ_UNUSED, 8'hA5);
		queue_other(REQ_WR_FLAG, 8'hFF);
		queue_other(REQ_WR_ENABLE, 8'hE0);
		queue_boundary(5'h00, 16'h1234, 16'hC000, 1'b0, 1'b0, 1'b1);
		queue_other(REQ_WR_ENABLE, 8'h10);
		// halted core wakes with the master enable off
		queue_boundary(5'h00, 16'h2345, 16'hC000, 1'b0, 1'b0, 1'b0);
		// enable promoted at once, joypad taken, stack wraps below zero
		queue_boundary(5'h00, 16'hFFFF, 16'h0000, 1'b1, 1'b0, 1'b0);
		queue_other(REQ_WR_ENABLE, 8'h1F);
		queue_other(REQ_WR_FLAG, 8'h00);
		queue_boundary(5'h1F, 16'h0100, 16'h0001, 1'b1, 1'b0, 1'b0);
		// enable and disable together: enable wins
		queue_boundary(5'h00, 16'h0200, 16'hFFFF, 1'b1, 1'b1, 1'b0);
		queue_boundary(5'h00, 16'h0300, 16'hFFFE, 1'b1, 1'b0, 1'b0);
		queue_boundary(5'h00, 16'h0400, 16'h8000, 1'b1, 1'b0, 1'b0);
		queue_boundary(5'h00, 16'h0500, 16'h0002, 1'b1, 1'b0, 1'b0);
		queue_boundary(5'h01, 16'h0600, 16'hDFFF, 1'b0, 1'b1, 1'b0);
		queue_boundary(5'h00, 16'h0700, 16'hD000, 1'b1, 1'b0, 1'b1);
		queue_boundary(5'h04, 16'h0800, 16'hD000, 1'b0, 1'b1, 1'b1);
		queue_other(REQ_WR_FLAG, 8'h00);
		queue_other(REQ_WR_ENABLE, 8'h00);
		queue_boundary(5'h1F, 16'h0900, 16'hD000, 1'b1, 1'b0, 1'b1);
		queue_other(REQ_WR_ENABLE, 8'hFF);
		queue_other(REQ_WR_FLAG, 8'hE0);
		queue_boundary(5'h00, 16'h0A00, 16'hD000, 1'b0, 1'b0, 1'b0);

		// Random traffic, mostly boundaries with sparse requests
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 8)
				queue_other(REQ_WR_FLAG, ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom));
			else if (pick < 16)
				queue_other(REQ_WR_ENABLE, 8'($urandom));
			else if (pick < 19)
				queue_other(REQ_UNUSED, 8'($urandom));
			else begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4: reqs = '0;
					5, 6, 7: reqs = 5'(1 << $urandom_range(0, 4));
					default: reqs = 5'($urandom);
				endcase
				case ($urandom_range(0, 9))
					0: sp = 16'h0000;
					1: sp = 16'h0001;
					default: sp = 16'($urandom);
				endcase
				queue_boundary(reqs, 16'($urandom), sp, $urandom_range(0, 9) < 3,
					$urandom_range(0, 19) < 3, $urandom_range(0, 19) < 3);
			end
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);

		$display("%0d items in, %0d results checked, %0d halted wakes", items_accepted,
			results_checked, wake_count);
		$display("interrupts taken per source (vblank..joypad): %0d %0d %0d %0d %0d",
			taken_per_source[0], taken_per_source[1], taken_per_source[2],
			taken_per_source[3], taken_per_source[4]);
		if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("tb_interrupt_priority_dispatch_top: clean");
		end else begin
			$display("tb_interrupt_priority_dispatch_top: errors");
		end
		$finish;
	end

endmodule
`default_nettype wire

>>> filelist.f
src/ipd_pkg.sv
src/ipd_stream_if.sv
src/ipd_eval.sv
src/interrupt_priority_dispatch_top.sv
src/ipd_checker.sv
verif/tb_interrupt_priority_dispatch_top.sv
